@@ rtl/crp_pkg.sv @@
// Shared constants and types for the color ramp interpolator.
`timescale 1ns / 1ps

package crp_pkg;

  localparam int MAX_STOPS  = 16;
  localparam int POS_BITS   = 16;
  localparam int ADDR_W     = $clog2(MAX_STOPS);
  localparam int CNT_W      = $clog2(MAX_STOPS + 1);
  localparam int RAMP_W     = 17;
  localparam int COLOR_W    = 32;

  localparam logic [POS_BITS-1:0] POS_FULL    = {POS_BITS{1'b1}};
  localparam logic [RAMP_W-1:0]   RAMP_RESET  = 17'd256;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  typedef struct packed {
    logic [POS_BITS-1:0] pos;
    logic [COLOR_W-1:0]  color;   // R low byte, then G, B, A
  } stop_t;

endpackage

@@ rtl/color_ramp_interpolator.sv @@
// Color ramp interpolator: sorted stop table and texel color query.
`timescale 1ns / 1ps

// Keeps up to 16 RGBA8 color stops sorted by position and answers texel
// queries with the linearly interpolated, truncated color at
// t = index / (ramp_length - 1). Clear never raises busy. Add moves each
// larger stop up one slot and then writes the new one; a full table drops
// the stop without raising busy. A query with an empty table returns zero
// without raising busy; otherwise it runs through one shared 33x17
// multiplier and a restoring divider that yields one quotient bit per cycle,
// returns the first or last stop if t is at or beyond it, and else searches
// the stops one at a time for the bracket and interpolates each channel in
// turn. The result appears on the out_ ports for one cycle with out_strobe
// high, with busy already low; it cannot be held off, so the receiver must
// take it then.
module color_ramp_interpolator
  import crp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_opcode,
  input  logic [15:0]         in_stop_position,
  input  logic [7:0]          in_stop_red,
  input  logic [7:0]          in_stop_green,
  input  logic [7:0]          in_stop_blue,
  input  logic [7:0]          in_stop_alpha,
  input  logic [15:0]         in_texel_index,
  output logic                out_strobe,
  output logic [7:0]          out_red,
  output logic [7:0]          out_green,
  output logic [7:0]          out_blue,
  output logic [7:0]          out_alpha,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [RAMP_W-1:0]   cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_INS  = 4'd1;
  localparam logic [3:0] S_TN   = 4'd2;
  localparam logic [3:0] S_P0   = 4'd3;
  localparam logic [3:0] S_C0   = 4'd4;
  localparam logic [3:0] S_PL   = 4'd5;
  localparam logic [3:0] S_CL   = 4'd6;
  localparam logic [3:0] S_PN   = 4'd7;
  localparam logic [3:0] S_CN   = 4'd8;
  localparam logic [3:0] S_MUL  = 4'd9;
  localparam logic [3:0] S_LD   = 4'd10;
  localparam logic [3:0] S_DIV  = 4'd11;
  localparam logic [3:0] S_FIN  = 4'd12;

  localparam int MA_W   = 33;
  localparam int MB_W   = 17;
  localparam int PROD_W = 41;

  // control state
  logic [3:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [RAMP_W-1:0] ramp_r;
  logic              strobe_r, strobe_nxt;

  // datapath
  stop_t             tbl_r [MAX_STOPS];
  stop_t             new_r, new_nxt;
  logic [15:0]       idx_r, idx_nxt;
  logic [ADDR_W-1:0] i_r, i_nxt;
  logic [31:0]       tn_r, tn_nxt;
  logic [32:0]       lo_r, lo_nxt;
  logic [32:0]       num_r, num_nxt;
  logic [32:0]       den_r, den_nxt;
  logic [COLOR_W-1:0] col_lo_r, col_lo_nxt;
  logic [COLOR_W-1:0] col_hi_r, col_hi_nxt;
  logic [COLOR_W-1:0] res_r, res_nxt;
  logic [COLOR_W-1:0] out_color_r, out_color_nxt;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] n_r, n_nxt;
  logic [PROD_W-1:0] dsh_r, dsh_nxt;
  logic [7:0]        q_r, q_nxt;
  logic [2:0]        bit_r, bit_nxt;
  logic [1:0]        ch_r, ch_nxt;

  logic [ADDR_W-1:0] rd_addr;
  stop_t             rd_stop;
  logic              tbl_we;
  logic [ADDR_W-1:0] tbl_wa;
  stop_t             tbl_wd;

  logic [MA_W-1:0]   ma;
  logic [MB_W-1:0]   mb;
  logic [MA_W+MB_W-1:0] mul_full;

  logic [RAMP_W-1:0] d_w;
  logic [15:0]       idx_eff;
  logic [7:0]        c0, c1, diff;
  logic              up;
  logic              ge;
  logic [ADDR_W-1:0] last_addr;

  assign busy       = (state_r != S_IDLE);
  assign cfg_ready  = !busy;
  assign out_strobe = strobe_r;
  assign out_red    = out_color_r[7:0];
  assign out_green  = out_color_r[15:8];
  assign out_blue   = out_color_r[23:16];
  assign out_alpha  = out_color_r[31:24];

  // short ramp: t = 0 for every index
  assign d_w       = (ramp_r < RAMP_W'(2)) ? RAMP_W'(1) : ramp_r - RAMP_W'(1);
  assign idx_eff   = (ramp_r < RAMP_W'(2)) ? 16'd0 : idx_r;
  assign last_addr = ADDR_W'(count_r - CNT_W'(1));

  assign c0   = col_lo_r[8*ch_r +: 8];
  assign c1   = col_hi_r[8*ch_r +: 8];
  assign up   = (c1 >= c0);
  assign diff = up ? c1 - c0 : c0 - c1;
  assign ge   = (n_r >= dsh_r);

  always_comb begin
    unique case (state_r)
      S_P0, S_C0: rd_addr = '0;
      S_PL, S_CL: rd_addr = last_addr;
      S_PN, S_CN: rd_addr = i_r + ADDR_W'(1);
      S_INS:      rd_addr = i_r - ADDR_W'(1);
      default:    rd_addr = '0;
    endcase
  end

  assign rd_stop = tbl_r[rd_addr];

  // shared multiplier operand select
  always_comb begin
    unique case (state_r)
      S_TN: begin
        ma = MA_W'(idx_eff);
        mb = MB_W'(POS_FULL);
      end
      S_P0, S_PL, S_PN: begin
        ma = MA_W'(rd_stop.pos);
        mb = d_w;
      end
      S_MUL: begin
        ma = num_r;
        mb = MB_W'(diff);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign mul_full = ma * mb;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    strobe_nxt    = 1'b0;
    new_nxt       = new_r;
    idx_nxt       = idx_r;
    i_nxt         = i_r;
    tn_nxt        = tn_r;
    lo_nxt        = lo_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    col_lo_nxt    = col_lo_r;
    col_hi_nxt    = col_hi_r;
    res_nxt       = res_r;
    out_color_nxt = out_color_r;
    n_nxt         = n_r;
    dsh_nxt       = dsh_r;
    q_nxt         = q_r;
    bit_nxt       = bit_r;
    ch_nxt        = ch_r;
    tbl_we        = 1'b0;
    tbl_wa        = i_r;
    tbl_wd        = new_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_opcode)
            OP_CLEAR: count_nxt = '0;
            OP_ADD: begin
              new_nxt.pos   = in_stop_position & POS_FULL;
              new_nxt.color = {in_stop_alpha, in_stop_blue, in_stop_green, in_stop_red};
              if (count_r < CNT_W'(MAX_STOPS)) begin
                i_nxt     = ADDR_W'(count_r);
                state_nxt = S_INS;
              end
            end
            OP_QUERY: begin
              idx_nxt = in_texel_index;
              if (count_r == '0) begin
                out_color_nxt = '0;
                strobe_nxt    = 1'b1;
              end else begin
                state_nxt = S_TN;
              end
            end
            default: ;
          endcase
        end
      end
      // insertion walk: shift larger stops up one slot
      S_INS: begin
        tbl_we = 1'b1;
        tbl_wa = i_r;
        if (i_r != '0 && rd_stop.pos > new_r.pos) begin
          tbl_wd = rd_stop;
          i_nxt  = i_r - ADDR_W'(1);
        end else begin
          tbl_wd    = new_r;
          count_nxt = count_r + CNT_W'(1);
          state_nxt = S_IDLE;
        end
      end
      S_TN: state_nxt = S_P0;
      S_P0: begin
        tn_nxt    = prod_r[31:0];
        state_nxt = S_C0;
      end
      S_C0: begin
        lo_nxt     = prod_r[32:0];
        col_lo_nxt = rd_stop.color;
        i_nxt      = '0;
        if ({9'd0, tn_r} <= prod_r) begin
          out_color_nxt = rd_stop.color;
          strobe_nxt    = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_PL;
        end
      end
      S_PL: state_nxt = S_CL;
      S_CL: begin
        if ({9'd0, tn_r} >= prod_r) begin
          out_color_nxt = rd_stop.color;
          strobe_nxt    = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_PN;
        end
      end
      S_PN: state_nxt = S_CN;
      // bracket search: advance while the next stop is strictly below t
      S_CN: begin
        if (prod_r < {9'd0, tn_r}) begin
          i_nxt      = i_r + ADDR_W'(1);
          lo_nxt     = prod_r[32:0];
          col_lo_nxt = rd_stop.color;
          state_nxt  = S_PN;
        end else begin
          col_hi_nxt = rd_stop.color;
          num_nxt    = {1'b0, tn_r} - lo_r;
          den_nxt    = prod_r[32:0] - lo_r;
          ch_nxt     = '0;
          state_nxt  = S_MUL;
        end
      end
      S_MUL: state_nxt = S_LD;
      S_LD: begin
        n_nxt     = prod_r;
        dsh_nxt   = {1'b0, den_r, 7'd0};
        q_nxt     = '0;
        bit_nxt   = 3'd7;
        state_nxt = S_DIV;
      end
      // quotient is below 256, so eight restoring steps suffice
      S_DIV: begin
        if (ge) n_nxt = n_r - dsh_r;
        q_nxt   = {q_r[6:0], ge};
        dsh_nxt = dsh_r >> 1;
        bit_nxt = bit_r - 3'd1;
        if (bit_r == 3'd0) state_nxt = S_FIN;
      end
      S_FIN: begin
        // falling channel: floor of c0 - x is c0 - ceil(x)
        if (up) res_nxt[8*ch_r +: 8] = c0 + q_r;
        else    res_nxt[8*ch_r +: 8] = c0 - q_r - {7'd0, (n_r != '0)};
        if (ch_r == 2'd3) begin
          out_color_nxt = res_nxt;
          strobe_nxt    = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          ch_nxt    = ch_r + 2'd1;
          state_nxt = S_MUL;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
      ramp_r   <= RAMP_RESET;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_valid && cfg_ready) ramp_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    new_r       <= new_nxt;
    idx_r       <= idx_nxt;
    i_r         <= i_nxt;
    tn_r        <= tn_nxt;
    lo_r        <= lo_nxt;
    num_r       <= num_nxt;
    den_r       <= den_nxt;
    col_lo_r    <= col_lo_nxt;
    col_hi_r    <= col_hi_nxt;
    res_r       <= res_nxt;
    out_color_r <= out_color_nxt;
    prod_r      <= mul_full[PROD_W-1:0];
    n_r         <= n_nxt;
    dsh_r       <= dsh_nxt;
    q_r         <= q_nxt;
    bit_r       <= bit_nxt;
    ch_r        <= ch_nxt;
    if (tbl_we) tbl_r[tbl_wa] <= tbl_wd;
  end

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while busy");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_STOPS))
    else $error("stop count beyond table depth");

  a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PN) |-> ({1'b0, i_r} + CNT_W'(1) < count_r))
    else $error("bracket search ran past the last stop");

  a_query_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TN) |-> (count_r != '0))
    else $error("interpolation started on an empty table");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS && state_nxt == S_IDLE) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow the table");

endmodule

@@ test/ramp_color_checker.sv @@
// Checker for the color ramp interpolator: predicts query colors and compares results.
`timescale 1ns / 1ps

module ramp_color_checker
  import crp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        in_opcode,
  input  logic [15:0]       in_stop_position,
  input  logic [7:0]        in_stop_red,
  input  logic [7:0]        in_stop_green,
  input  logic [7:0]        in_stop_blue,
  input  logic [7:0]        in_stop_alpha,
  input  logic [15:0]       in_texel_index,
  input  logic              out_strobe,
  input  logic [7:0]        out_red,
  input  logic [7:0]        out_green,
  input  logic [7:0]        out_blue,
  input  logic [7:0]        out_alpha,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [RAMP_W-1:0] cfg_data,
  output int                errors,
  output int                pending
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  logic [POS_BITS-1:0] stop_pos_tbl  [MAX_STOPS];
  logic [COLOR_W-1:0]  stop_rgba_tbl [MAX_STOPS];
  int unsigned         stop_total;
  logic [RAMP_W-1:0]   ramp_len;
  rgba_t               color_q [$];
  rgba_t               want;
  rgba_t               got;
  int                  fail_count = 0;

  function automatic rgba_t unpack_rgba(input logic [COLOR_W-1:0] w);
    rgba_t c;
    c.red   = w[7:0];
    c.green = w[15:8];
    c.blue  = w[23:16];
    c.alpha = w[31:24];
    return c;
  endfunction

  // Insertion keeps the table sorted; equal positions land after existing ones.
  task automatic insert_stop(input logic [POS_BITS-1:0] pos, input logic [COLOR_W-1:0] rgba);
    int unsigned i;
    if (stop_total >= MAX_STOPS) return;
    i = stop_total;
    while (i > 0 && stop_pos_tbl[i-1] > pos) begin
      stop_pos_tbl[i]  = stop_pos_tbl[i-1];
      stop_rgba_tbl[i] = stop_rgba_tbl[i-1];
      i--;
    end
    stop_pos_tbl[i]  = pos;
    stop_rgba_tbl[i] = rgba;
    stop_total++;
  endtask

  // Exact rational interpolation: t is compared as index*POS_FULL against pos*(len-1).
  function automatic rgba_t ramp_color(input logic [15:0] texel);
    bit [63:0]          span;
    bit [63:0]          t_scaled;
    bit [63:0]          lo;
    bit [63:0]          hi;
    bit [63:0]          frac;
    bit [63:0]          width;
    bit [63:0]          c0;
    bit [63:0]          c1;
    bit [63:0]          mix;
    logic [COLOR_W-1:0] blend;
    int unsigned        seg;
    int                 k;
    if (stop_total == 0) return '0;
    if (ramp_len < 2) begin
      span     = 64'd1;
      t_scaled = 64'd0;
    end else begin
      span     = 64'(ramp_len) - 64'd1;
      t_scaled = 64'(texel) * 64'(POS_FULL);
    end
    if (t_scaled <= 64'(stop_pos_tbl[0]) * span) return unpack_rgba(stop_rgba_tbl[0]);
    if (t_scaled >= 64'(stop_pos_tbl[stop_total-1]) * span)
      return unpack_rgba(stop_rgba_tbl[stop_total-1]);
    seg = 0;
    while (seg + 1 < stop_total && 64'(stop_pos_tbl[seg+1]) * span < t_scaled) seg++;
    lo    = 64'(stop_pos_tbl[seg]) * span;
    hi    = 64'(stop_pos_tbl[seg+1]) * span;
    frac  = t_scaled - lo;
    width = hi - lo;
    for (k = 0; k < 4; k++) begin
      c0  = 64'(stop_rgba_tbl[seg][8*k +: 8]);
      c1  = 64'(stop_rgba_tbl[seg+1][8*k +: 8]);
      mix = (c0 * (width - frac) + c1 * frac) / width;
      blend[8*k +: 8] = mix[7:0];
    end
    return unpack_rgba(blend);
  endfunction

  task automatic check_chan(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      stop_total = 0;
      ramp_len   = RAMP_RESET;
      color_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) ramp_len = cfg_data;
      if (out_strobe) begin
        got.red   = out_red;
        got.green = out_green;
        got.blue  = out_blue;
        got.alpha = out_alpha;
        if (color_q.size() == 0) begin
          $error("result strobe with no query outstanding");
          fail_count++;
        end else begin
          want = color_q.pop_front();
          check_chan("out_red", want.red, got.red);
          check_chan("out_green", want.green, got.green);
          check_chan("out_blue", want.blue, got.blue);
          check_chan("out_alpha", want.alpha, got.alpha);
        end
      end
      if (start && !busy) begin
        case (in_opcode)
          OP_CLEAR: stop_total = 0;
          OP_ADD:   insert_stop(in_stop_position,
                                {in_stop_alpha, in_stop_blue, in_stop_green, in_stop_red});
          OP_QUERY: color_q.insert(color_q.size(), ramp_color(in_texel_index));
          default: ;
        endcase
      end
    end
    pending <= color_q.size();
    errors  <= fail_count;
  end

endmodule

@@ test/testbench.sv @@
// Top of the color ramp interpolator test: stimulus, ramp length phases and verdict.
`timescale 1ns / 1ps

module testbench;
  import crp_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int         PHASES    = 9;
  localparam int         PHASE_OPS = 180;
  localparam int         SETTLE    = 120;

  logic              clk;
  logic              rst_n            = 1'b0;
  logic              start            = 1'b0;
  logic              busy;
  logic [1:0]        in_opcode        = '0;
  logic [15:0]       in_stop_position = '0;
  logic [7:0]        in_stop_red      = '0;
  logic [7:0]        in_stop_green    = '0;
  logic [7:0]        in_stop_blue     = '0;
  logic [7:0]        in_stop_alpha    = '0;
  logic [15:0]       in_texel_index   = '0;
  logic              out_strobe;
  logic [7:0]        out_red;
  logic [7:0]        out_green;
  logic [7:0]        out_blue;
  logic [7:0]        out_alpha;
  logic              cfg_valid        = 1'b0;
  logic              cfg_ready;
  logic [RAMP_W-1:0] cfg_data         = '0;
  int                errors;
  int                pending;

  int unsigned       cur_ramp   = 256;
  int unsigned       sent_ops   = 0;
  int                burst_left = 0;
  logic [15:0]       last_pos   = '0;
  logic [RAMP_W-1:0] ramp_plan [PHASES];

  color_ramp_interpolator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_stop_position (in_stop_position),
    .in_stop_red      (in_stop_red),
    .in_stop_green    (in_stop_green),
    .in_stop_blue     (in_stop_blue),
    .in_stop_alpha    (in_stop_alpha),
    .in_texel_index   (in_texel_index),
    .out_strobe       (out_strobe),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  ramp_color_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_stop_position (in_stop_position),
    .in_stop_red      (in_stop_red),
    .in_stop_green    (in_stop_green),
    .in_stop_blue     (in_stop_blue),
    .in_stop_alpha    (in_stop_alpha),
    .in_texel_index   (in_texel_index),
    .out_strobe       (out_strobe),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .errors           (errors),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Holds start high until the transaction is taken; start stays high on return.
  task automatic issue(input logic [1:0] op, input logic [15:0] pos, input logic [31:0] rgba,
                       input logic [15:0] idx);
    in_opcode        <= op;
    in_stop_position <= pos;
    in_stop_red      <= rgba[7:0];
    in_stop_green    <= rgba[15:8];
    in_stop_blue     <= rgba[23:16];
    in_stop_alpha    <= rgba[31:24];
    in_texel_index   <= idx;
    start            <= 1'b1;
    do @(posedge clk); while (busy);
    if (op != OP_UNUSED) sent_ops++;
  endtask

  task automatic idle(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Bursts of random length; now and then a long one with no gaps at all.
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      idle($urandom_range(1, 12));
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 20);
    end
  endtask

  // One cycle first so the checker's count covers the last accepted transaction.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_ramp(input logic [RAMP_W-1:0] len);
    cfg_data  <= len;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_ramp = 32'(len);
  endtask

  function automatic logic [15:0] pick_position();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return last_pos;
      3:       return 16'($urandom_range(0, 255) * 257);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_index();
    int unsigned top_idx;
    if (cur_ramp < 2 || $urandom_range(0, 9) == 0) return 16'($urandom);
    top_idx = (cur_ramp - 1 > 65535) ? 65535 : cur_ramp - 1;
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'(top_idx);
      default: return 16'($urandom_range(0, top_idx));
    endcase
  endfunction

  // Mostly clear / fill / query runs; the rest is stray opcodes and runs with no clear.
  task automatic run_sequence();
    int unsigned n_add;
    int unsigned n_query;
    int unsigned j;
    logic [15:0] pos;
    if ($urandom_range(0, 9) == 0) begin
      issue(2'($urandom), 16'($urandom), $urandom, 16'($urandom));
      pace();
      return;
    end
    n_add   = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 8);
    n_query = $urandom_range(1, 10);
    if ($urandom_range(0, 5) != 0) begin
      issue(OP_CLEAR, 16'($urandom), $urandom, 16'($urandom));
      pace();
    end
    for (j = 0; j < n_add; j++) begin
      pos = pick_position();
      last_pos = pos;
      issue(OP_ADD, pos, $urandom, 16'($urandom));
      pace();
    end
    for (j = 0; j < n_query; j++) begin
      issue(OP_QUERY, 16'($urandom), $urandom, pick_index());
      pace();
    end
    if ($urandom_range(0, 24) == 0) drain();
  endtask

  initial begin
    int p;
    int unsigned goal;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset ramp length of 256, back to back
    issue(OP_QUERY, 16'd0, 32'h0, 16'd0);
    issue(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    issue(OP_ADD, 16'd32768, 32'h8040_2010, 16'd0);
    issue(OP_QUERY, 16'd0, 32'h0, 16'd0);
    issue(OP_QUERY, 16'd0, 32'h0, 16'd255);
    issue(OP_ADD, 16'd0, 32'h0000_0000, 16'd0);
    issue(OP_ADD, 16'hFFFF, 32'hFFFF_FFFF, 16'd0);
    issue(OP_ADD, 16'd32768, 32'h1122_3344, 16'd0);
    issue(OP_QUERY, 16'd0, 32'h0, 16'd64);
    issue(OP_QUERY, 16'd0, 32'h0, 16'd128);
    issue(OP_QUERY, 16'd0, 32'h0, 16'd200);
    issue(OP_QUERY, 16'd0, 32'h0, 16'd255);
    issue(OP_QUERY, 16'd0, 32'h0, 16'hFFFF);
    issue(OP_CLEAR, 16'd0, 32'h0, 16'd0);
    issue(OP_QUERY, 16'd0, 32'h0, 16'd5);
    issue(OP_ADD, 16'hFFFF, 32'hA0B0_C0D0, 16'd0);
    issue(OP_ADD, 16'hFFFF, 32'h0102_0304, 16'd0);
    issue(OP_QUERY, 16'd0, 32'h0, 16'd0);
    issue(OP_QUERY, 16'd0, 32'h0, 16'd255);
    issue(OP_CLEAR, 16'd0, 32'h0, 16'd0);

    ramp_plan[0] = 17'd2;
    ramp_plan[1] = 17'd65536;
    ramp_plan[2] = 17'd0;
    ramp_plan[3] = 17'd1;
    ramp_plan[4] = 17'd131071;
    ramp_plan[5] = 17'd16;
    ramp_plan[6] = 17'($urandom_range(3, 1024));
    ramp_plan[7] = 17'($urandom_range(0, 131071));
    ramp_plan[8] = RAMP_RESET;

    for (p = 0; p < PHASES; p++) begin
      drain();
      write_ramp(ramp_plan[p]);
      goal = sent_ops + PHASE_OPS;
      while (sent_ops < goal) run_sequence();
    end
    drain();

    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
